### src/rgbcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbcc_pkg
// shared types and constants of the rgb color classifier
// ----------------------------------------------------------------------------
package rgbcc_pkg;

	// request kinds carried in tuser
	localparam logic FUNC_CAL      = 1'b0;
	localparam logic FUNC_CLASSIFY = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_BLANK_LIMIT_HIGH = 2'd0;
	localparam logic [1:0] REG_BLANK_LIMIT_LOW  = 2'd1;

	// calibration table geometry
	localparam int NUM_COLS = 4;
	localparam int NUM_ROWS = 3;
	localparam logic [1:0] ROW_HIGH = 2'd0;
	localparam logic [1:0] ROW_MID  = 2'd1;
	localparam logic [1:0] ROW_LOW  = 2'd2;

	// field widths
	localparam int RAW_W  = 11;
	localparam int WORD_W = 32;
	localparam int CAL_W  = 16;
	localparam int LIM_W  = 16;
	// clamped blank times 100 fits in 18 bits
	localparam int X_W    = 18;

	typedef enum logic [2:0] {
		HUE_BLACK  = 3'd0,
		HUE_BLUE   = 3'd1,
		HUE_GREEN  = 3'd2,
		HUE_YELLOW = 3'd3,
		HUE_RED    = 3'd4,
		HUE_WHITE  = 3'd5
	} color_t;

endpackage
`default_nettype wire

### src/rgbcc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbcc_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module rgbcc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 3
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### src/rgbcc_classify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbcc_classify
// decision tree from calibrated channel values to a color code
// ----------------------------------------------------------------------------
module rgbcc_classify import rgbcc_pkg::*; (
	input  wire logic [CAL_W-1:0] red,
	input  wire logic [CAL_W-1:0] green,
	input  wire logic [CAL_W-1:0] blue,
	input  wire logic [CAL_W-1:0] blank,
	output color_t                color
);

	logic [CAL_W+2:0] blue_sum;     // blue + blue/4 + blue/8
	logic [CAL_W+1:0] green_x2;
	logic [CAL_W+1:0] green_rd;     // 2*green - green/4
	logic [CAL_W+1:0] blue_x2;
	logic [CAL_W+1:0] red_125;
	logic [CAL_W+1:0] blue_125;
	logic [CAL_W+1:0] red_1125;
	logic [CAL_W+1:0] green_1125;
	logic [CAL_W+5:0] red_48;
	logic [CAL_W+5:0] green_48;
	logic [CAL_W+5:0] red_58;
	logic [CAL_W+5:0] green_58;

	always_comb begin
		blue_sum   = (CAL_W+3)'(blue) + (CAL_W+3)'(blue >> 2) + (CAL_W+3)'(blue >> 3);
		green_x2   = (CAL_W+2)'(green) << 1;
		green_rd   = green_x2 - (CAL_W+2)'(green >> 2);
		blue_x2    = (CAL_W+2)'(blue) << 1;
		red_125    = (CAL_W+2)'(red) + (CAL_W+2)'(red >> 2);
		blue_125   = (CAL_W+2)'(blue) + (CAL_W+2)'(blue >> 2);
		red_1125   = (CAL_W+2)'(red) + (CAL_W+2)'(red >> 3);
		green_1125 = (CAL_W+2)'(green) + (CAL_W+2)'(green >> 3);
		red_48     = ((CAL_W+6)'(red) * (CAL_W+6)'(48)) >> 5;
		green_48   = ((CAL_W+6)'(green) * (CAL_W+6)'(48)) >> 5;
		red_58     = ((CAL_W+6)'(red) * (CAL_W+6)'(58)) >> 5;
		green_58   = ((CAL_W+6)'(green) * (CAL_W+6)'(58)) >> 5;

		if (red > blue && red > green) begin
			// red dominant
			if (red < 65 || (blank < 40 && red < 110)) begin
				color = HUE_BLACK;
			end else if (blue_sum < (CAL_W+3)'(green) && green_x2 > (CAL_W+2)'(red)) begin
				color = HUE_YELLOW;
			end else if (green_rd < (CAL_W+2)'(red)) begin
				color = HUE_RED;
			end else if (blue < 70 || green < 70 || (blank < 140 && red < 140)) begin
				color = HUE_BLACK;
			end else begin
				color = HUE_WHITE;
			end
		end else if (green > blue) begin
			// green dominant (also wins a tie with red above blue)
			if (green < 40 || (blank < 30 && green < 70)) begin
				color = HUE_BLACK;
			end else if (blue_x2 < (CAL_W+2)'(red)) begin
				color = HUE_YELLOW;
			end else if (red_125 < (CAL_W+2)'(green) || blue_125 < (CAL_W+2)'(green)) begin
				color = HUE_GREEN;
			end else if (red < 70 || blue < 70 || (blank < 140 && green < 140)) begin
				color = HUE_BLACK;
			end else begin
				color = HUE_WHITE;
			end
		end else begin
			// blue at least as large as red and green (blue wins ties)
			if (blue < 48 || (blank < 25 && blue < 85)) begin
				color = HUE_BLACK;
			end else if ((red_48 < (CAL_W+6)'(blue) && green_48 < (CAL_W+6)'(blue)) ||
					red_58 < (CAL_W+6)'(blue) || green_58 < (CAL_W+6)'(blue)) begin
				color = HUE_BLUE;
			end else if (red < 60 || green < 60 || (blank < 110 && blue < 120)) begin
				color = HUE_BLACK;
			end else if (red_1125 < (CAL_W+2)'(blue) || green_1125 < (CAL_W+2)'(blue)) begin
				color = HUE_BLUE;
			end else begin
				color = HUE_WHITE;
			end
		end
	end

endmodule
`default_nettype wire

### src/rgb_color_classifier_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_color_classifier_core
// calibrates raw light readings and classifies them as one of six colors
// ----------------------------------------------------------------------------
// usage
//   s_axis carries requests; tuser picks the kind. a calibration request
//   (tuser 0) writes one gain word into the 3x4 table and returns nothing.
//   a classify request (tuser 1) carries blank, red, green, blue readings and
//   returns one result on m_axis: color plus four calibrated values.
//   cfg writes the two blank limit registers; they pick the table row. the user must see
//   that they are written only while no classify request is in flight; the block does not enforce this.
// throughput and pipeline
//   one request per cycle while m_axis takes results; once taken, a request
//   passes the table read, gain and reciprocal multiply, quotient fix-up,
//   ambient gain multiply, and decision tree into the output register.
//   a table write and a later read are always on different cycles, so a
//   classify right after a calibration write sees the new word.
// reset and stall
//   reset empties the pipeline and clears the limits; the table is undefined
//   until written. a stall on m_axis holds the output register; bubbles in
//   the pipeline still close up, and s_axis tready drops once all are full.
// ----------------------------------------------------------------------------
module rgb_color_classifier_core import rgbcc_pkg::*; #(
	parameter int MIN_BLANK   = 214,
	parameter int SENSOR_FULL = 1023,
	parameter int ADC_FULL    = 1023
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// request channel
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// cal_index[3:0], cal_word[35:4], raw_blank[46:36], raw_red[57:47],
	// raw_green[68:58], raw_blue[79:69]
	input  wire logic [79:0]  s_axis_tdata,
	// func
	input  wire logic         s_axis_tuser,
	// result channel
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// color[2:0], cal_red[34:3], cal_green[66:35], cal_blue[98:67],
	// cal_ambient[130:99], zero fill[135:131]
	output logic [135:0]      m_axis_tdata,
	// configuration write channel
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [15:0]  cfg_data
);

	// ambient scaling: s = b * 100 / DIV, divide done by reciprocal multiply
	localparam int DIV_RAW = ((SENSOR_FULL - MIN_BLANK) * 100) / ADC_FULL;
	localparam int DIV     = (DIV_RAW < 1) ? 1 : DIV_RAW;
	localparam int KSH     = X_W + $clog2(DIV) + 1;
	localparam int MW      = X_W + 2;
	localparam logic [MW-1:0]    RECIP   = MW'((64'd1 << KSH) / DIV);
	localparam logic [X_W-1:0]   DIV_C   = X_W'(DIV);
	localparam logic [RAW_W-1:0] MIN_B_C = RAW_W'(MIN_BLANK);

	// ---------------- configuration ----------------
	logic [LIM_W-1:0] lim_high_q;
	logic [LIM_W-1:0] lim_low_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_high_q <= '0;
			lim_low_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BLANK_LIMIT_HIGH: lim_high_q <= cfg_data;
				REG_BLANK_LIMIT_LOW:  lim_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic out_valid_q;
	logic adv1, adv2, adv3, adv4, adv_out;

	// a stage may load when it is empty or its content moves on
	assign adv_out = !out_valid_q || m_axis_tready;
	assign adv4    = !valid_s4 || adv_out;
	assign adv3    = !valid_s3 || adv4;
	assign adv2    = !valid_s2 || adv3;
	assign adv1    = !valid_s1 || adv2;

	assign s_axis_tready = adv1;
	assign m_axis_tvalid = out_valid_q;

	logic s_accept;
	logic is_cal;
	logic is_cls;
	assign s_accept = s_axis_tvalid && s_axis_tready;
	assign is_cal   = s_accept && (s_axis_tuser == FUNC_CAL);
	assign is_cls   = s_accept && (s_axis_tuser == FUNC_CLASSIFY);

	// ---------------- request fields ----------------
	logic [3:0]       in_index;
	logic [WORD_W-1:0] in_word;
	logic [RAW_W-1:0] in_blank, in_red, in_green, in_blue;

	assign in_index = s_axis_tdata[3:0];
	assign in_word  = s_axis_tdata[35:4];
	assign in_blank = s_axis_tdata[46:36];
	assign in_red   = s_axis_tdata[57:47];
	assign in_green = s_axis_tdata[68:58];
	assign in_blue  = s_axis_tdata[79:69];

	// ---------------- stage 0: row pick, table access ----------------
	logic [1:0]       row_sel;
	logic [RAW_W-1:0] amb_clamp;
	logic [RAW_W-1:0] dr_in, dg_in, db_in;
	logic             wr_ok;

	always_comb begin
		if (LIM_W'(in_blank) < lim_low_q) begin
			row_sel = ROW_LOW;
		end else if (LIM_W'(in_blank) < lim_high_q) begin
			row_sel = ROW_MID;
		end else begin
			row_sel = ROW_HIGH;
		end
		amb_clamp = (in_blank > MIN_B_C) ? in_blank - MIN_B_C : '0;
		dr_in     = (in_red > in_blank) ? in_red - in_blank : '0;
		dg_in     = (in_green > in_blank) ? in_green - in_blank : '0;
		db_in     = (in_blue > in_blank) ? in_blue - in_blank : '0;
	end

	// rows 0..2 only; index 12..15 is dropped
	assign wr_ok = is_cal && (in_index[3:2] != 2'd3);

	// one ram per column so a whole row reads out together
	logic [WORD_W-1:0] gain_s1 [NUM_COLS];

	for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
		rgbcc_ram #(
			.WIDTH (WORD_W),
			.DEPTH (NUM_ROWS)
		) u_ram (
			.clk   (clk),
			.we    (wr_ok && (in_index[1:0] == 2'(c))),
			.waddr (in_index[3:2]),
			.wdata (in_word),
			.re    (is_cls),
			.raddr (row_sel),
			.rdata (gain_s1[c])
		);
	end

	logic [X_W-1:0]   x_s1;
	logic [RAW_W-1:0] dr_s1, dg_s1, db_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= is_cls;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			x_s1  <= X_W'(amb_clamp) * X_W'(100);
			dr_s1 <= dr_in;
			dg_s1 <= dg_in;
			db_s1 <= db_in;
		end
	end

	// ---------------- stage 1: gain multiplies, reciprocal multiply ----------------
	logic [WORD_W-1:0]  pr, pg, pb;
	logic [X_W+MW-1:0]  dprod;

	always_comb begin
		pr    = WORD_W'(dr_s1) * gain_s1[0];
		pg    = WORD_W'(dg_s1) * gain_s1[1];
		pb    = WORD_W'(db_s1) * gain_s1[2];
		dprod = (X_W+MW)'(x_s1) * (X_W+MW)'(RECIP);
	end

	logic [CAL_W-1:0]  cr_s2, cg_s2, cb_s2;
	logic [X_W-1:0]    q_s2;
	logic [X_W-1:0]    x_s2;
	logic [WORD_W-1:0] gamb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			cr_s2   <= pr[WORD_W-1:WORD_W-CAL_W];
			cg_s2   <= pg[WORD_W-1:WORD_W-CAL_W];
			cb_s2   <= pb[WORD_W-1:WORD_W-CAL_W];
			q_s2    <= X_W'(dprod >> KSH);
			x_s2    <= x_s1;
			gamb_s2 <= gain_s1[3];
		end
	end

	// ---------------- stage 2: quotient fix-up ----------------
	// estimate is the true quotient or one below it
	logic [X_W-1:0] rem;
	logic [X_W-1:0] quot;

	always_comb begin
		rem  = x_s2 - X_W'(q_s2 * DIV_C);
		quot = (rem >= DIV_C) ? q_s2 + X_W'(1) : q_s2;
	end

	logic [CAL_W-1:0]  cr_s3, cg_s3, cb_s3;
	logic [X_W-1:0]    s_s3;
	logic [WORD_W-1:0] gamb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			cr_s3   <= cr_s2;
			cg_s3   <= cg_s2;
			cb_s3   <= cb_s2;
			s_s3    <= quot;
			gamb_s3 <= gamb_s2;
		end
	end

	// ---------------- stage 3: ambient gain multiply ----------------
	logic [WORD_W-1:0] pa;
	assign pa = WORD_W'(s_s3) * gamb_s3;

	logic [CAL_W-1:0] cr_s4, cg_s4, cb_s4, ca_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			cr_s4 <= cr_s3;
			cg_s4 <= cg_s3;
			cb_s4 <= cb_s3;
			ca_s4 <= pa[WORD_W-1:WORD_W-CAL_W];
		end
	end

	// ---------------- stage 4: decision tree, output register ----------------
	color_t color_s4;

	rgbcc_classify u_classify (
		.red   (cr_s4),
		.green (cg_s4),
		.blue  (cb_s4),
		.blank (ca_s4),
		.color (color_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			m_axis_tdata <= {5'b0,
				WORD_W'(ca_s4), WORD_W'(cb_s4), WORD_W'(cg_s4), WORD_W'(cr_s4),
				color_s4};
		end
	end

	// ---------------- assertions ----------------
	// a result only ever comes out of a filled last stage
	a_out_from_s4: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s4))
		else $error("result appeared without a request in the last stage");

	// a held first stage keeps its request
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv1) |=> (valid_s1 && $stable(x_s1) && $stable(dr_s1)))
		else $error("stalled first stage lost its request");

	// a write and a read of the table never share a cycle
	a_ram_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_ok && is_cls))
		else $error("table write and read in the same cycle");

	// a stall must not drop a request in the last stage
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && !adv4) |=> valid_s4)
		else $error("stalled last stage dropped its request");

endmodule
`default_nettype wire
